/* rtl/core/debounced_threshold_alarm_core_assert.svh */
// Assertion macros shared by the alarm core modules.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef DEBOUNCED_THRESHOLD_ALARM_CORE_ASSERT_SVH
`define DEBOUNCED_THRESHOLD_ALARM_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Property checked on every clock edge outside reset.
`define DTA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("dta assertion failed");
// Property checked on every clock edge, reset included.
`define DTA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("dta assertion failed");
`else
`define DTA_ASSERT(lbl, clk, rstn, prop)
`define DTA_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* rtl/core/dta_pkg.sv */
// Package for the debounced threshold alarm core: codes, widths, structs.
// No dependencies; imported by all core modules.
`timescale 1ns / 1ps
package dta_pkg;

  localparam int CountWidth = 8;   // saturating counter width (2..16)
  localparam int DebWidth   = 8;   // debounce register width
  localparam int CmpWidth   = (CountWidth > DebWidth) ? CountWidth : DebWidth;
  localparam int ValWidth   = 16;  // common signed width for both channels
  localparam int FieldWidth = 15;
  localparam int NumLanes   = 2;
  localparam int QueueDepth = 4;
  localparam int CritDev    = 500; // 5.00 in hundredths
  localparam int WarnDev    = 200; // 2.00 in hundredths

  typedef enum logic [1:0] {
    KindHigh    = 2'd0,
    KindLow     = 2'd1,
    KindRecover = 2'd2,
    KindStatus  = 2'd3
  } dta_kind_e;

  typedef enum logic [1:0] {
    SevInfo = 2'd0,
    SevWarn = 2'd1,
    SevCrit = 2'd2
  } dta_sev_e;

  typedef enum logic {
    ChanTemp = 1'b0,
    ChanHum  = 1'b1
  } dta_chan_e;

  typedef enum logic {
    FuncSample = 1'b0,
    FuncClear  = 1'b1
  } dta_func_e;

  typedef enum logic [2:0] {
    RegEnable  = 3'd0,
    RegTempLo  = 3'd1,
    RegTempHi  = 3'd2,
    RegHumLo   = 3'd3,
    RegHumHi   = 3'd4,
    RegDebounce = 3'd5
  } dta_reg_e;

  typedef struct packed {
    logic                       eval;     // accepted, enabled sample
    logic                       clr_all;  // clear command
    logic                       clr_cnt;  // configuration write
    dta_chan_e                  chan;
    logic signed [ValWidth-1:0] value;
    logic signed [ValWidth-1:0] lo;
    logic signed [ValWidth-1:0] hi;
    logic [DebWidth-1:0]        debounce;
  } dta_lane_ctl_t;

  typedef struct packed {
    logic                  fire;
    dta_kind_e             kind;
    dta_sev_e              sev;
    logic [FieldWidth-1:0] value;
    logic [FieldWidth-1:0] thr;
    logic                  listed_q;
    logic                  listed_d;
  } dta_lane_res_t;

  typedef struct packed {
    dta_chan_e             chan;
    dta_kind_e             kind;
    dta_sev_e              sev;
    logic [FieldWidth-1:0] value;
    logic [FieldWidth-1:0] thr;
    logic [1:0]            mask;
    logic                  last;
  } dta_result_t;

endpackage

/* rtl/core/dta_in_if.sv */
// Sample/command input channel of the alarm core.
// Depends on nothing; widths fixed by the sample format.
`timescale 1ns / 1ps
interface dta_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [14:0] temp_sample;
  logic [13:0] hum_sample;

  modport source (output valid, func, temp_sample, hum_sample, input ready);
  modport sink (input valid, func, temp_sample, hum_sample, output ready);
endinterface

/* rtl/core/dta_out_if.sv */
// Event output channel of the alarm core.
// Depends on nothing; widths fixed by the event format.
`timescale 1ns / 1ps
interface dta_out_if;
  logic        valid;
  logic        ready;
  logic        event_channel;
  logic [1:0]  event_kind;
  logic [1:0]  severity;
  logic [14:0] event_value;
  logic [14:0] event_threshold;
  logic [1:0]  active_mask;
  logic        last;

  modport source (output valid, event_channel, event_kind, severity, event_value,
                  event_threshold, active_mask, last, input ready);
  modport sink (input valid, event_channel, event_kind, severity, event_value,
                event_threshold, active_mask, last, output ready);
endinterface

/* rtl/core/dta_cfg_if.sv */
// Configuration write channel of the alarm core.
// Depends on nothing; data is as wide as the widest register.
`timescale 1ns / 1ps
interface dta_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  reg_idx;
  logic [14:0] wdata;

  modport source (output valid, reg_idx, wdata, input ready);
  modport sink (input valid, reg_idx, wdata, output ready);
endinterface

/* rtl/core/dta_lane.sv */
// One channel lane: window compare, debounce counters, alarm flags, severity.
// Depends on dta_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "debounced_threshold_alarm_core_assert.svh"
module dta_lane
  import dta_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dta_lane_ctl_t ctl_i,
  output dta_lane_res_t res_o
);

  logic [CountWidth-1:0] above_q, above_d, below_q, below_d, rec_q, rec_d;
  logic                  hi_flag_q, hi_flag_d, lo_flag_q, lo_flag_d;
  logic                  listed_q, listed_d;

  logic                  above, below, idle, trig_hi, trig_lo, recover;
  logic [CountWidth-1:0] above_inc, below_inc, rec_inc;
  logic [CmpWidth-1:0]   deb_ext;
  logic signed [ValWidth-1:0] thr;
  logic signed [ValWidth:0]   diff;
  logic [ValWidth:0]          mag;
  dta_sev_e                   trig_sev;

  function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] c);
    sat_inc = (&c) ? c : c + CountWidth'(1);
  endfunction

  always_comb begin
    above     = ctl_i.value > ctl_i.hi;
    below     = ctl_i.value < ctl_i.lo;
    above_inc = above ? sat_inc(above_q) : '0;
    below_inc = below ? sat_inc(below_q) : '0;
    rec_inc   = (!above && !below) ? sat_inc(rec_q) : '0;
    deb_ext   = CmpWidth'(ctl_i.debounce);
    idle      = !hi_flag_q && !lo_flag_q;
    trig_hi   = idle && (CmpWidth'(above_inc) >= deb_ext);
    trig_lo   = idle && !trig_hi && (CmpWidth'(below_inc) >= deb_ext);
    recover   = !idle && (CmpWidth'(rec_inc) >= deb_ext);

    thr  = trig_lo ? ctl_i.lo : ctl_i.hi;
    diff = {ctl_i.value[ValWidth-1], ctl_i.value} - {thr[ValWidth-1], thr};
    mag  = diff[ValWidth] ? (~diff + (ValWidth+1)'(1)) : diff;
    if (ctl_i.chan == ChanHum) begin
      trig_sev = SevWarn;
    end else if (mag > (ValWidth+1)'(CritDev)) begin
      trig_sev = SevCrit;
    end else if (mag > (ValWidth+1)'(WarnDev)) begin
      trig_sev = SevWarn;
    end else begin
      trig_sev = SevInfo;
    end
  end

  always_comb begin
    above_d   = above_q;
    below_d   = below_q;
    rec_d     = rec_q;
    hi_flag_d = hi_flag_q;
    lo_flag_d = lo_flag_q;
    listed_d  = listed_q;
    if (ctl_i.clr_all) begin
      above_d = '0; below_d = '0; rec_d = '0;
      hi_flag_d = 1'b0; lo_flag_d = 1'b0; listed_d = 1'b0;
    end else if (ctl_i.clr_cnt) begin
      // keep the listed mark across a config write
      above_d = '0; below_d = '0; rec_d = '0;
      hi_flag_d = 1'b0; lo_flag_d = 1'b0;
    end else if (ctl_i.eval) begin
      above_d = above_inc;
      below_d = below_inc;
      if (trig_hi) begin
        hi_flag_d = 1'b1;
        below_d   = '0;
        listed_d  = 1'b1;
      end else if (trig_lo) begin
        lo_flag_d = 1'b1;
        above_d   = '0;
        listed_d  = 1'b1;
      end else if (!idle) begin
        rec_d = recover ? '0 : rec_inc;
        if (recover) begin
          hi_flag_d = 1'b0;
          lo_flag_d = 1'b0;
          listed_d  = 1'b0;
        end
      end
    end
  end

  always_comb begin
    res_o.fire     = ctl_i.eval && !ctl_i.clr_all && !ctl_i.clr_cnt &&
                     (trig_hi || trig_lo || recover);
    res_o.kind     = trig_hi ? KindHigh : (trig_lo ? KindLow : KindRecover);
    res_o.sev      = (trig_hi || trig_lo) ? trig_sev : SevInfo;
    res_o.value    = ctl_i.value[FieldWidth-1:0];
    res_o.thr      = thr[FieldWidth-1:0];
    res_o.listed_q = listed_q;
    res_o.listed_d = listed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      above_q   <= '0;
      below_q   <= '0;
      rec_q     <= '0;
      hi_flag_q <= 1'b0;
      lo_flag_q <= 1'b0;
      listed_q  <= 1'b0;
    end else begin
      above_q   <= above_d;
      below_q   <= below_d;
      rec_q     <= rec_d;
      hi_flag_q <= hi_flag_d;
      lo_flag_q <= lo_flag_d;
      listed_q  <= listed_d;
    end
  end

  `DTA_ASSERT_ALWAYS(a_flags_excl, clk_i, !(hi_flag_q && lo_flag_q))
  `DTA_ASSERT(a_clear_all, clk_i, rst_ni, ctl_i.clr_all |=> (!listed_q && idle && above_q == '0))
  `DTA_ASSERT(a_fire_on_eval, clk_i, rst_ni, res_o.fire |-> ctl_i.eval)

endmodule

/* rtl/core/dta_merge.sv */
// Merge stage: orders lane events, fixes masks and last, queues results.
// Depends on dta_pkg, dta_out_if and the assertion macro header.
`timescale 1ns / 1ps
`include "debounced_threshold_alarm_core_assert.svh"
module dta_merge
  import dta_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         smp_acc_i,
  input  logic                         clr_acc_i,
  input  dta_lane_res_t [NumLanes-1:0] lane_i,
  output logic                         in_ready_o,
  dta_out_if.source                    res_o
);

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  dta_result_t         q_q [QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_nxt;
  logic [CntW-1:0]     count_q, count_d;
  dta_result_t         r0, r1, ev_temp, ev_hum;
  logic [1:0]          n;
  logic                pop;

  always_comb begin
    // temperature goes first, so its mask still shows the old humidity mark
    ev_temp.chan  = ChanTemp;
    ev_temp.kind  = lane_i[0].kind;
    ev_temp.sev   = lane_i[0].sev;
    ev_temp.value = lane_i[0].value;
    ev_temp.thr   = lane_i[0].thr;
    ev_temp.mask  = {lane_i[1].listed_q, lane_i[0].listed_d};
    ev_temp.last  = !lane_i[1].fire;

    ev_hum.chan  = ChanHum;
    ev_hum.kind  = lane_i[1].kind;
    ev_hum.sev   = lane_i[1].sev;
    ev_hum.value = lane_i[1].value;
    ev_hum.thr   = lane_i[1].thr;
    ev_hum.mask  = {lane_i[1].listed_d, lane_i[0].listed_d};
    ev_hum.last  = 1'b1;

    r1 = ev_hum;
    if (clr_acc_i) begin
      r0      = '0;
      r0.kind = KindStatus;
      r0.last = 1'b1;
      n = (lane_i[0].listed_q || lane_i[1].listed_q) ? 2'd1 : 2'd0;
    end else if (smp_acc_i) begin
      r0 = lane_i[0].fire ? ev_temp : ev_hum;
      n  = 2'({1'b0, lane_i[0].fire} + {1'b0, lane_i[1].fire});
    end else begin
      r0 = ev_temp;
      n  = 2'd0;
    end
  end

  always_comb begin
    pop        = res_o.valid && res_o.ready;
    in_ready_o = count_q <= CntW'(QueueDepth - 2);
    wr_nxt     = wr_ptr_q + PtrW'(1);
    wr_ptr_d   = wr_ptr_q + PtrW'(n);
    rd_ptr_d   = rd_ptr_q + PtrW'(pop);
    count_d    = count_q + CntW'(n) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n != 2'd0) begin
      q_q[wr_ptr_q] <= r0;
    end
    if (n == 2'd2) begin
      q_q[wr_nxt] <= r1;
    end
  end

  assign res_o.valid           = count_q != '0;
  assign res_o.event_channel   = q_q[rd_ptr_q].chan;
  assign res_o.event_kind      = q_q[rd_ptr_q].kind;
  assign res_o.severity        = q_q[rd_ptr_q].sev;
  assign res_o.event_value     = q_q[rd_ptr_q].value;
  assign res_o.event_threshold = q_q[rd_ptr_q].thr;
  assign res_o.active_mask     = q_q[rd_ptr_q].mask;
  assign res_o.last            = q_q[rd_ptr_q].last;

  `DTA_ASSERT(a_no_overflow, clk_i, rst_ni, count_q <= CntW'(QueueDepth))
  `DTA_ASSERT(a_push_room, clk_i, rst_ni, (n != 2'd0) |-> in_ready_o)
  `DTA_ASSERT(a_pop_only, clk_i, rst_ni, (pop && n == 2'd0) |=> (count_q == $past(count_q) - CntW'(1)))

endmodule

/* rtl/core/debounced_threshold_alarm_core.sv */
// Debounced window threshold alarm: two channel lanes, event merge queue.
// Depends on dta_pkg, dta_in_if, dta_out_if, dta_cfg_if, dta_lane, dta_merge.
//
// Usage:
//   sample_i carries one beat per sample or clear command (func). Each beat
//   updates the temperature and humidity lanes in the cycle it is accepted;
//   the lanes work side by side and the merge stage writes their events
//   (temperature first) into a four-entry result queue.
//   result_o delivers the events, one per beat, last marking the final event
//   of a sample. The events of a beat are written into the queue as it is accepted.
//   Throughput: one sample per cycle while the queue holds two or fewer
//   events; a sample with two events needs two result beats to drain.
//   When the receiver stalls, events stay in the queue and sample_i.ready
//   drops once fewer than two queue entries are free.
//   cfg_i is always ready; write registers only while no events are pending.
//   Reset loads the default limits and clears all counters, flags and the
//   result queue; no clearing pass is needed.
`timescale 1ns / 1ps
module debounced_threshold_alarm_core
  import dta_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  dta_in_if.sink     sample_i,
  dta_cfg_if.sink    cfg_i,
  dta_out_if.source  result_o
);

  logic [2:0]            enable_q;
  logic signed [14:0]    temp_lo_q, temp_hi_q;
  logic [13:0]           hum_lo_q, hum_hi_q;
  logic [DebWidth-1:0]   deb_q;

  logic                  in_ready, in_acc, smp_acc, clr_acc, cfg_acc, cfg_hit;
  dta_lane_ctl_t [NumLanes-1:0] lane_ctl;
  dta_lane_res_t [NumLanes-1:0] lane_res;

  assign cfg_i.ready     = 1'b1;
  assign sample_i.ready  = in_ready;
  assign in_acc          = sample_i.valid && in_ready;
  assign smp_acc         = in_acc && (sample_i.func == FuncSample);
  assign clr_acc         = in_acc && (sample_i.func == FuncClear);
  assign cfg_acc         = cfg_i.valid && cfg_i.ready;

  always_comb begin
    case (cfg_i.reg_idx)
      RegEnable, RegTempLo, RegTempHi, RegHumLo, RegHumHi, RegDebounce: cfg_hit = 1'b1;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 3'd7;
      temp_lo_q <= 15'sd1000;
      temp_hi_q <= 15'sd3500;
      hum_lo_q  <= 14'd2000;
      hum_hi_q  <= 14'd8000;
      deb_q     <= DebWidth'(3);
    end else if (cfg_acc) begin
      case (cfg_i.reg_idx)
        RegEnable:   enable_q  <= cfg_i.wdata[2:0];
        RegTempLo:   temp_lo_q <= cfg_i.wdata;
        RegTempHi:   temp_hi_q <= cfg_i.wdata;
        RegHumLo:    hum_lo_q  <= cfg_i.wdata[13:0];
        RegHumHi:    hum_hi_q  <= cfg_i.wdata[13:0];
        RegDebounce: deb_q     <= cfg_i.wdata[DebWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    lane_ctl[0].eval     = smp_acc && enable_q[0] && enable_q[1];
    lane_ctl[0].clr_all  = clr_acc;
    lane_ctl[0].clr_cnt  = cfg_acc && cfg_hit;
    lane_ctl[0].chan     = ChanTemp;
    lane_ctl[0].value    = {sample_i.temp_sample[14], sample_i.temp_sample};
    lane_ctl[0].lo       = {temp_lo_q[14], temp_lo_q};
    lane_ctl[0].hi       = {temp_hi_q[14], temp_hi_q};
    lane_ctl[0].debounce = deb_q;

    lane_ctl[1].eval     = smp_acc && enable_q[0] && enable_q[2];
    lane_ctl[1].clr_all  = clr_acc;
    lane_ctl[1].clr_cnt  = cfg_acc && cfg_hit;
    lane_ctl[1].chan     = ChanHum;
    lane_ctl[1].value    = {2'b00, sample_i.hum_sample};
    lane_ctl[1].lo       = {2'b00, hum_lo_q};
    lane_ctl[1].hi       = {2'b00, hum_hi_q};
    lane_ctl[1].debounce = deb_q;
  end

  dta_lane u_lane_temp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (lane_ctl[0]),
    .res_o  (lane_res[0])
  );

  dta_lane u_lane_hum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (lane_ctl[1]),
    .res_o  (lane_res[1])
  );

  dta_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .smp_acc_i  (smp_acc),
    .clr_acc_i  (clr_acc),
    .lane_i     (lane_res),
    .in_ready_o (in_ready),
    .res_o      (result_o)
  );

endmodule
